// ===== design/fdm_pkg.sv =====
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared types and status codes for the floored divide/modulo pipeline.
// ----------------------------------------------------------------------------
package fdm_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Control that travels down the pipeline next to each item
  typedef struct packed {
    logic       valid;
    logic       a_neg;
    logic       b_neg;
    logic [1:0] status;
  } fdm_ctl_t;

endpackage

// ===== design/fdm_chan_if.sv =====
// ----------------------------------------------------------------------------
// fdm channel interfaces
// Valid/ready channels for operand pairs and for divide results.
// ----------------------------------------------------------------------------
interface fdm_in_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] dividend;
  logic signed [WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface fdm_out_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] quotient;
  logic signed [WIDTH-1:0] remainder;
  logic [1:0]              status;

  modport source (output valid, output quotient, output remainder, output status,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input status,
                  output ready);
endinterface

// ===== design/fdm_pre.sv =====
// ----------------------------------------------------------------------------
// fdm_pre
// Input stage: flag special cases and take operand magnitudes.
// ----------------------------------------------------------------------------
module fdm_pre import fdm_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output fdm_ctl_t         ctl_r,
  output logic [WIDTH-1:0] ma_r,
  output logic [WIDTH-1:0] mb_r
);

  localparam logic [WIDTH-1:0] SBIT = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] ONES = {WIDTH{1'b1}};

  fdm_ctl_t         ctl_nxt;
  logic [WIDTH-1:0] ma_nxt;
  logic [WIDTH-1:0] mb_nxt;

  always_comb begin
    ctl_nxt.valid = in_valid;
    ctl_nxt.a_neg = a[WIDTH-1];
    ctl_nxt.b_neg = b[WIDTH-1];
    if (b == '0) begin
      ctl_nxt.status = ST_DIV_ZERO;
    end else if (a == SBIT && b == ONES) begin
      ctl_nxt.status = ST_OVERFLOW;
    end else begin
      ctl_nxt.status = ST_OK;
    end
    ma_nxt = a[WIDTH-1] ? (-a) : a;
    mb_nxt = b[WIDTH-1] ? (-b) : b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= ma_nxt;
      mb_r <= mb_nxt;
    end
  end

endmodule

// ===== design/fdm_stage.sv =====
// ----------------------------------------------------------------------------
// fdm_stage
// One restoring divide step: develop one quotient bit per stage.
// ----------------------------------------------------------------------------
module fdm_stage import fdm_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  fdm_ctl_t         ctl_in,
  input  logic [WIDTH-1:0] rem_in,
  input  logic [WIDTH-1:0] quo_in,
  input  logic [WIDTH-1:0] mb_in,
  output fdm_ctl_t         ctl_r,
  output logic [WIDTH-1:0] rem_r,
  output logic [WIDTH-1:0] quo_r,
  output logic [WIDTH-1:0] mb_r
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;
  logic             take;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_in, quo_in[WIDTH-1]};
    trial   = shifted - {1'b0, mb_in};
    take    = ~trial[WIDTH];
    rem_nxt = take ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
    quo_nxt = {quo_in[WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      mb_r  <= mb_in;
    end
  end

endmodule

// ===== design/fdm_post.sv =====
// ----------------------------------------------------------------------------
// fdm_post
// Output stage: apply floor rounding and signs, register the result.
// ----------------------------------------------------------------------------
module fdm_post import fdm_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  fdm_ctl_t         ctl_in,
  input  logic [WIDTH-1:0] uq,
  input  logic [WIDTH-1:0] ur,
  input  logic [WIDTH-1:0] mb,
  output logic             valid_r,
  output logic [WIDTH-1:0] q_r,
  output logic [WIDTH-1:0] r_r,
  output logic [1:0]       status_r
);

  localparam logic [WIDTH-1:0] SBIT = {1'b1, {(WIDTH-1){1'b0}}};

  logic [WIDTH-1:0] q_nxt;
  logic [WIDTH-1:0] r_nxt;

  always_comb begin
    q_nxt = '0;
    r_nxt = '0;
    if (ctl_in.status == ST_OVERFLOW) begin
      q_nxt = SBIT;
    end else if (ctl_in.status == ST_OK) begin
      if (ctl_in.a_neg == ctl_in.b_neg) begin
        q_nxt = uq;
        r_nxt = ctl_in.b_neg ? (-ur) : ur;
      end else if (ur == '0) begin
        q_nxt = -uq;
      end else begin
        // round down past the truncated quotient; -(uq + 1) is ~uq
        q_nxt = ~uq;
        r_nxt = ctl_in.b_neg ? (ur - mb) : (mb - ur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r      <= q_nxt;
      r_r      <= r_nxt;
      status_r <= ctl_in.status;
    end
  end

endmodule

// ===== design/floored_divide_modulo_top.sv =====
// ----------------------------------------------------------------------------
// floored_divide_modulo_top
// Pipelined signed divider giving floored quotient, remainder and status.
// ----------------------------------------------------------------------------
// The block takes one dividend/divisor transfer per cycle while the output
// is not stalled and returns one result per transfer, in order, after it has
// passed one input stage, WIDTH restoring subtract stages (one quotient bit
// each) and one output stage. The quotient rounds toward minus
// infinity and the remainder takes the sign of the divisor. A zero divisor
// gives quotient 0, remainder 0, status 1; the most negative value divided
// by minus one gives the wrapped quotient, remainder 0, status 2. The whole
// pipeline advances together: while a result sits unaccepted at the output,
// in_chan.ready drops and every stage holds.
// ----------------------------------------------------------------------------
module floored_divide_modulo_top import fdm_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  fdm_in_if.sink    in_chan,
  fdm_out_if.source out_chan
);

  localparam logic [WIDTH-1:0] SBIT = {1'b1, {(WIDTH-1){1'b0}}};

  // Advance every stage when the output register is empty or being taken
  logic adv;

  fdm_ctl_t         ctl   [WIDTH+1];
  logic [WIDTH-1:0] rem   [WIDTH+1];
  logic [WIDTH-1:0] quo   [WIDTH+1];
  logic [WIDTH-1:0] mbv   [WIDTH+1];

  logic             out_valid;
  logic [WIDTH-1:0] out_q;
  logic [WIDTH-1:0] out_rem;
  logic [1:0]       out_status;

  assign adv           = ~out_valid | out_chan.ready;
  assign in_chan.ready = adv;

  // Stage 0: special-case flags and magnitudes; partial remainder starts at 0
  fdm_pre #(.WIDTH(WIDTH)) u_pre (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_chan.valid),
    .a        (in_chan.dividend),
    .b        (in_chan.divisor),
    .ctl_r    (ctl[0]),
    .ma_r     (quo[0]),
    .mb_r     (mbv[0])
  );
  assign rem[0] = '0;

  // Restoring divide chain, most significant quotient bit first
  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    fdm_stage #(.WIDTH(WIDTH)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .ctl_in (ctl[i]),
      .rem_in (rem[i]),
      .quo_in (quo[i]),
      .mb_in  (mbv[i]),
      .ctl_r  (ctl[i+1]),
      .rem_r  (rem[i+1]),
      .quo_r  (quo[i+1]),
      .mb_r   (mbv[i+1])
    );
  end

  // Output register: floor adjustment and remainder sign
  fdm_post #(.WIDTH(WIDTH)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .ctl_in   (ctl[WIDTH]),
    .uq       (quo[WIDTH]),
    .ur       (rem[WIDTH]),
    .mb       (mbv[WIDTH]),
    .valid_r  (out_valid),
    .q_r      (out_q),
    .r_r      (out_rem),
    .status_r (out_status)
  );

  assign out_chan.valid     = out_valid;
  assign out_chan.quotient  = out_q;
  assign out_chan.remainder = out_rem;
  assign out_chan.status    = out_status;

  // Divide by zero must come out as all-zero values
  a_div_zero_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DIV_ZERO) |-> (out_q == '0 && out_rem == '0))
    else $error("divide by zero result not cleared");

  // Overflow must give the wrapped quotient and zero remainder
  a_overflow_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVERFLOW) |-> (out_q == SBIT && out_rem == '0))
    else $error("overflow result wrong");

  // A held result keeps its values until taken
  a_hold_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_chan.ready) |=> (out_valid && $stable(out_q) &&
                                        $stable(out_rem) && $stable(out_status)))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
